>>> rtl/ppdbrf_pkg.sv
// Shared types and constants for the ping-pong DMA buffer ring feeder.
`default_nettype none
package ppdbrf_pkg;

  localparam int unsigned MODE_W          = 2;
  localparam int unsigned SLOT_W          = 3;
  localparam int unsigned PURGED_W        = 4;
  localparam int unsigned HIGH_W          = 4;
  localparam int unsigned CTR_W           = 32;
  localparam int unsigned RESERVED_SLOTS  = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WRITE    = 2'd0,
    MODE_DMA_DONE = 2'd1,
    MODE_PURGE    = 2'd2
  } mode_t;

  typedef struct packed {
    logic                write_accepted;
    logic                load_a;
    logic                zero_a;
    logic [SLOT_W-1:0]   slot_a;
    logic                load_b;
    logic                zero_b;
    logic [SLOT_W-1:0]   slot_b;
    logic [PURGED_W-1:0] purged_buffers;
    logic                space_available;
    logic [CTR_W-1:0]    user_urun_total;
    logic [CTR_W-1:0]    irq_urun_total;
    logic [HIGH_W-1:0]   high_water;
  } result_t;

endpackage : ppdbrf_pkg
`default_nettype wire

>>> rtl/ppdbrf_evt_if.sv
// Event channel: valid/ready handshake carrying one ring event.
`default_nettype none
interface ppdbrf_evt_if;
  import ppdbrf_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic              status_buffer_b_in_use;
  logic              status_started_a;
  logic              status_started_b;

  modport source (
    output valid, mode, status_buffer_b_in_use, status_started_a, status_started_b,
    input  ready
  );
  modport sink (
    input  valid, mode, status_buffer_b_in_use, status_started_a, status_started_b,
    output ready
  );
endinterface : ppdbrf_evt_if
`default_nettype wire

>>> rtl/ppdbrf_res_if.sv
// Result channel: valid/ready handshake carrying one event result.
`default_nettype none
interface ppdbrf_res_if;
  import ppdbrf_pkg::*;

  logic                valid;
  logic                ready;
  logic                write_accepted;
  logic                load_a;
  logic                zero_a;
  logic [SLOT_W-1:0]   slot_a;
  logic                load_b;
  logic                zero_b;
  logic [SLOT_W-1:0]   slot_b;
  logic [PURGED_W-1:0] purged_buffers;
  logic                space_available;
  logic [CTR_W-1:0]    user_urun_total;
  logic [CTR_W-1:0]    irq_urun_total;
  logic [HIGH_W-1:0]   high_water;

  modport source (
    output valid, write_accepted, load_a, zero_a, slot_a, load_b, zero_b, slot_b,
           purged_buffers, space_available, user_urun_total, irq_urun_total, high_water,
    input  ready
  );
  modport sink (
    input  valid, write_accepted, load_a, zero_a, slot_a, load_b, zero_b, slot_b,
           purged_buffers, space_available, user_urun_total, irq_urun_total, high_water,
    output ready
  );
endinterface : ppdbrf_res_if
`default_nettype wire

>>> rtl/pingpong_dma_buffer_ring_feeder_core.sv
// Top level of the ping-pong DMA buffer ring feeder.
//
// Tracks a ring of NUM_BUFFERS buffer slots that feed two DMA channels, two slots
// always being held back for the channels in flight. Each transfer on the evt
// channel is one event: a producer write of a full buffer, a DMA-done interrupt
// carrying the channel status, or a purge. Each event yields exactly one transfer
// on the res channel with the write verdict, the channel reloads, the purge count
// and the running underrun counters and high-water mark.
// The result is registered, and an event's result is shown on res from the cycle after it is taken.
// Throughput is one event per cycle while res is not stalled; the ring state is updated
// by a single pass of combinational logic and is ready for the following event at once.
// The result sits in an output register; while res is stalled with a result held,
// evt.ready is low, and it rises in the same cycle that the held result is taken.
// Synchronous reset empties the ring, clears the good-data flag, both underrun
// counters and the high-water mark, and drops any held result.
`default_nettype none
module pingpong_dma_buffer_ring_feeder_core #(
  parameter int unsigned NUM_BUFFERS = 8
) (
  input wire logic     clk,
  input wire logic     rst,
  ppdbrf_evt_if.sink   evt,
  ppdbrf_res_if.source res
);
  import ppdbrf_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BUFFERS);
  localparam int unsigned CNT_W = $clog2(NUM_BUFFERS + 1);
  localparam logic [CNT_W-1:0] FREE_INIT = CNT_W'(NUM_BUFFERS - RESERVED_SLOTS);

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] used;
  logic [CNT_W-1:0] free;
  logic             data_live;
  logic [CTR_W-1:0] user_ctr;
  logic [CTR_W-1:0] irq_ctr;
  logic [CNT_W-1:0] high_mark;

  logic [IDX_W-1:0] head_next;
  logic [IDX_W-1:0] tail_next;
  logic [CNT_W-1:0] used_next;
  logic [CNT_W-1:0] free_next;
  logic             data_live_next;
  logic [CTR_W-1:0] user_ctr_next;
  logic [CTR_W-1:0] irq_ctr_next;
  logic [CNT_W-1:0] high_mark_next;

  result_t result;
  result_t res_q;
  logic    res_valid;
  logic    evt_take;

  assign evt.ready = !res_valid || res.ready;
  assign evt_take  = evt.valid && evt.ready;

  ppdbrf_event #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_event (
    .mode                   (evt.mode),
    .status_buffer_b_in_use (evt.status_buffer_b_in_use),
    .status_started_a       (evt.status_started_a),
    .status_started_b       (evt.status_started_b),
    .head                   (head),
    .tail                   (tail),
    .used                   (used),
    .free                   (free),
    .data_live              (data_live),
    .user_ctr               (user_ctr),
    .irq_ctr                (irq_ctr),
    .high_mark              (high_mark),
    .head_next              (head_next),
    .tail_next              (tail_next),
    .used_next              (used_next),
    .free_next              (free_next),
    .data_live_next         (data_live_next),
    .user_ctr_next          (user_ctr_next),
    .irq_ctr_next           (irq_ctr_next),
    .high_mark_next         (high_mark_next),
    .result                 (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      tail      <= '0;
      used      <= '0;
      free      <= FREE_INIT;
      data_live <= 1'b0;
      user_ctr  <= '0;
      irq_ctr   <= '0;
      high_mark <= '0;
    end else if (evt_take) begin
      head      <= head_next;
      tail      <= tail_next;
      used      <= used_next;
      free      <= free_next;
      data_live <= data_live_next;
      user_ctr  <= user_ctr_next;
      irq_ctr   <= irq_ctr_next;
      high_mark <= high_mark_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (evt_take) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (evt_take) begin
      res_q <= result;
    end
  end

  assign res.valid           = res_valid;
  assign res.write_accepted  = res_q.write_accepted;
  assign res.load_a          = res_q.load_a;
  assign res.zero_a          = res_q.zero_a;
  assign res.slot_a          = res_q.slot_a;
  assign res.load_b          = res_q.load_b;
  assign res.zero_b          = res_q.zero_b;
  assign res.slot_b          = res_q.slot_b;
  assign res.purged_buffers  = res_q.purged_buffers;
  assign res.space_available = res_q.space_available;
  assign res.user_urun_total = res_q.user_urun_total;
  assign res.irq_urun_total  = res_q.irq_urun_total;
  assign res.high_water      = res_q.high_water;

endmodule : pingpong_dma_buffer_ring_feeder_core
`default_nettype wire

>>> rtl/ppdbrf_event.sv
// Next-state and result logic for one ring event.
`default_nettype none
module ppdbrf_event #(
  parameter int unsigned NUM_BUFFERS = 8
) (
  input  wire logic [ppdbrf_pkg::MODE_W-1:0]         mode,
  input  wire logic                                  status_buffer_b_in_use,
  input  wire logic                                  status_started_a,
  input  wire logic                                  status_started_b,
  input  wire logic [$clog2(NUM_BUFFERS)-1:0]        head,
  input  wire logic [$clog2(NUM_BUFFERS)-1:0]        tail,
  input  wire logic [$clog2(NUM_BUFFERS+1)-1:0]      used,
  input  wire logic [$clog2(NUM_BUFFERS+1)-1:0]      free,
  input  wire logic                                  data_live,
  input  wire logic [ppdbrf_pkg::CTR_W-1:0]          user_ctr,
  input  wire logic [ppdbrf_pkg::CTR_W-1:0]          irq_ctr,
  input  wire logic [$clog2(NUM_BUFFERS+1)-1:0]      high_mark,
  output logic      [$clog2(NUM_BUFFERS)-1:0]        head_next,
  output logic      [$clog2(NUM_BUFFERS)-1:0]        tail_next,
  output logic      [$clog2(NUM_BUFFERS+1)-1:0]      used_next,
  output logic      [$clog2(NUM_BUFFERS+1)-1:0]      free_next,
  output logic                                       data_live_next,
  output logic      [ppdbrf_pkg::CTR_W-1:0]          user_ctr_next,
  output logic      [ppdbrf_pkg::CTR_W-1:0]          irq_ctr_next,
  output logic      [$clog2(NUM_BUFFERS+1)-1:0]      high_mark_next,
  output ppdbrf_pkg::result_t                        result
);
  import ppdbrf_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_BUFFERS);
  localparam int unsigned CNT_W = $clog2(NUM_BUFFERS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_BUFFERS - 1);
  localparam logic [CNT_W-1:0] FREE_INIT = CNT_W'(NUM_BUFFERS - RESERVED_SLOTS);

  logic             first_a;
  logic             second;
  logic             first_zero;
  logic             second_zero;
  logic [IDX_W-1:0] tail1;
  logic [IDX_W-1:0] tail2;
  logic [CNT_W-1:0] used1;
  logic [CNT_W-1:0] used2;
  logic [CNT_W-1:0] free1;
  logic [CNT_W-1:0] free2;
  logic [CNT_W-1:0] used_inc;
  logic [IDX_W+SLOT_W-1:0]   slot1_ext;
  logic [IDX_W+SLOT_W-1:0]   slot2_ext;
  logic [CNT_W+PURGED_W-1:0] purged_ext;
  logic [CNT_W+HIGH_W-1:0]   high_ext;
  logic [SLOT_W-1:0] slot1;
  logic [SLOT_W-1:0] slot2;

  // Channel A goes first when B is busy with a live transfer, or when B is idle and
  // A has stopped.
  assign first_a = (status_buffer_b_in_use && status_started_b) ||
                   (!status_buffer_b_in_use && !status_started_a);
  assign second  = first_a ? !status_started_b : !status_started_a;

  // First refill, from the current state.
  assign first_zero = (used == '0);
  assign tail1      = first_zero ? tail : ((tail == LAST_IDX) ? '0 : tail + 1'b1);
  assign used1      = first_zero ? used : used - 1'b1;
  assign free1      = first_zero ? free : free + 1'b1;
  assign slot1_ext  = {{SLOT_W{1'b0}}, tail};
  assign slot1      = first_zero ? '0 : slot1_ext[SLOT_W-1:0];

  // Second refill sees what the first one left behind.
  assign second_zero = (used1 == '0);
  assign tail2       = second_zero ? tail1 : ((tail1 == LAST_IDX) ? '0 : tail1 + 1'b1);
  assign used2       = second_zero ? used1 : used1 - 1'b1;
  assign free2       = second_zero ? free1 : free1 + 1'b1;
  assign slot2_ext   = {{SLOT_W{1'b0}}, tail1};
  assign slot2       = second_zero ? '0 : slot2_ext[SLOT_W-1:0];

  assign used_inc   = used + 1'b1;
  assign purged_ext = {{PURGED_W{1'b0}}, used};

  always_comb begin
    head_next      = head;
    tail_next      = tail;
    used_next      = used;
    free_next      = free;
    data_live_next = data_live;
    user_ctr_next  = user_ctr;
    irq_ctr_next   = irq_ctr;
    high_mark_next = high_mark;
    result         = '0;
    case (mode)
      MODE_WRITE: begin
        if (free != '0) begin
          free_next             = free - 1'b1;
          head_next             = (head == LAST_IDX) ? '0 : head + 1'b1;
          used_next             = used_inc;
          high_mark_next        = (used_inc > high_mark) ? used_inc : high_mark;
          data_live_next        = 1'b1;
          result.write_accepted = 1'b1;
        end
      end
      MODE_DMA_DONE: begin
        // Only the first channel's zero-page fallback marks the end of good data.
        if (first_zero && data_live) begin
          data_live_next = 1'b0;
          user_ctr_next  = user_ctr + 1'b1;
        end
        if (second) begin
          irq_ctr_next = irq_ctr + 1'b1;
          tail_next    = tail2;
          used_next    = used2;
          free_next    = free2;
        end else begin
          tail_next = tail1;
          used_next = used1;
          free_next = free1;
        end
        if (first_a) begin
          result.load_a = 1'b1;
          result.zero_a = first_zero;
          result.slot_a = slot1;
          result.load_b = second;
          result.zero_b = second && second_zero;
          result.slot_b = second ? slot2 : '0;
        end else begin
          result.load_b = 1'b1;
          result.zero_b = first_zero;
          result.slot_b = slot1;
          result.load_a = second;
          result.zero_a = second && second_zero;
          result.slot_a = second ? slot2 : '0;
        end
      end
      MODE_PURGE: begin
        result.purged_buffers = purged_ext[PURGED_W-1:0];
        head_next             = '0;
        tail_next             = '0;
        used_next             = '0;
        free_next             = FREE_INIT;
      end
      default: begin
      end
    endcase
    high_ext               = {{HIGH_W{1'b0}}, high_mark_next};
    result.space_available = (free_next != '0);
    result.user_urun_total = user_ctr_next;
    result.irq_urun_total  = irq_ctr_next;
    result.high_water      = high_ext[HIGH_W-1:0];
  end

endmodule : ppdbrf_event
`default_nettype wire

>>> rtl/ppdbrf_checker.sv
// Port-level checks for the ring feeder, bound to its top level.
`default_nettype none
module ppdbrf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic evt_valid,
  input wire logic evt_ready,
  input wire logic res_valid,
  input wire logic res_ready,
  input wire logic res_write_accepted,
  input wire logic res_load_a,
  input wire logic res_zero_a,
  input wire logic res_load_b,
  input wire logic res_zero_b,
  input wire logic [ppdbrf_pkg::CTR_W-1:0] res_irq_total
);
  import ppdbrf_pkg::*;

  // A stalled result stays offered, with its IRQ underrun total unchanged, until it is transferred.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_irq_total))
    else $error("result changed or vanished while stalled");

  // Every accepted event produces a result in the following cycle.
  a_evt_to_res: assert property (@(posedge clk) disable iff (rst)
    evt_valid && evt_ready |=> res_valid)
    else $error("accepted event gave no result");

  // No new event may be taken while a result is held and not being taken.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !evt_ready)
    else $error("event accepted over a stalled result");

  // The zero page is only ever named for a channel that is loaded, and a write
  // never reloads a channel.
  a_res_coherent: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (!res_zero_a || res_load_a) && (!res_zero_b || res_load_b) &&
                  !(res_write_accepted && (res_load_a || res_load_b)))
    else $error("inconsistent channel load fields");

endmodule : ppdbrf_checker

bind pingpong_dma_buffer_ring_feeder_core ppdbrf_checker u_ppdbrf_checker (
  .clk                (clk),
  .rst                (rst),
  .evt_valid          (evt.valid),
  .evt_ready          (evt.ready),
  .res_valid          (res.valid),
  .res_ready          (res.ready),
  .res_write_accepted (res.write_accepted),
  .res_load_a         (res.load_a),
  .res_zero_a         (res.zero_a),
  .res_load_b         (res.load_b),
  .res_zero_b         (res.zero_b),
  .res_irq_total      (res.irq_urun_total)
);
`default_nettype wire

>>> dv/ppdbrf_result_check.sv
// Result checker for the ring feeder: predicts each event's result and compares it.
`timescale 1ns / 1ps
module ppdbrf_result_check #(
  parameter int unsigned NUM_BUFFERS = 8
) (
  input  logic        clk,
  input  logic        rst,
  ppdbrf_evt_if       evt,
  ppdbrf_res_if       res,
  output int unsigned mismatches,
  output int unsigned pending
);
  import ppdbrf_pkg::*;

  // Predicted ring state.
  int unsigned       head_idx;
  int unsigned       tail_idx;
  int unsigned       used_cnt;
  int unsigned       free_cnt;
  logic              data_live;
  logic [CTR_W-1:0]  user_ctr;
  logic [CTR_W-1:0]  irq_ctr;
  int unsigned       high_mark;

  result_t expected_results[$];

  function automatic int unsigned ring_next(input int unsigned idx);
    return (idx + 1 >= NUM_BUFFERS) ? 0 : idx + 1;
  endfunction

  // Refills one channel from the tail slot, or from the zero page when the ring is empty.
  // Only the first channel of an event may end the good-data run.
  function automatic void take_buffer(input logic first, output logic zero,
                                      output logic [SLOT_W-1:0] slot);
    if (used_cnt == 0) begin
      zero = 1'b1;
      slot = '0;
      if (first && data_live) begin
        data_live = 1'b0;
        user_ctr  = user_ctr + 1'b1;
      end
    end else begin
      zero     = 1'b0;
      slot     = SLOT_W'(tail_idx);
      tail_idx = ring_next(tail_idx);
      used_cnt = used_cnt - 1;
      free_cnt = free_cnt + 1;
    end
  endfunction

  function automatic result_t ring_event(input logic [MODE_W-1:0] mode, input logic b_in_use,
                                         input logic started_a, input logic started_b);
    result_t r;
    logic    a_first;
    r       = '0;
    a_first = (b_in_use && started_b) || (!b_in_use && !started_a);
    case (mode)
      MODE_WRITE: begin
        if (free_cnt > 0) begin
          free_cnt = free_cnt - 1;
          head_idx = ring_next(head_idx);
          used_cnt = used_cnt + 1;
          if (used_cnt > high_mark) high_mark = used_cnt;
          data_live        = 1'b1;
          r.write_accepted = 1'b1;
        end
      end
      MODE_DMA_DONE: begin
        if (a_first) begin
          r.load_a = 1'b1;
          take_buffer(1'b1, r.zero_a, r.slot_a);
          if (!started_b) begin
            irq_ctr  = irq_ctr + 1'b1;
            r.load_b = 1'b1;
            take_buffer(1'b0, r.zero_b, r.slot_b);
          end
        end else begin
          r.load_b = 1'b1;
          take_buffer(1'b1, r.zero_b, r.slot_b);
          if (!started_a) begin
            irq_ctr  = irq_ctr + 1'b1;
            r.load_a = 1'b1;
            take_buffer(1'b0, r.zero_a, r.slot_a);
          end
        end
      end
      MODE_PURGE: begin
        r.purged_buffers = PURGED_W'(used_cnt);
        head_idx = 0;
        tail_idx = 0;
        used_cnt = 0;
        free_cnt = NUM_BUFFERS - RESERVED_SLOTS;
      end
      default: ;
    endcase
    r.space_available = (free_cnt > 0);
    r.user_urun_total = user_ctr;
    r.irq_urun_total  = irq_ctr;
    r.high_water      = HIGH_W'(high_mark);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CTR_W-1:0] want,
                             input logic [CTR_W-1:0] got);
    if (got !== want) begin
      if (mismatches < 10)
        $display("%0t: %s differs, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      head_idx   = 0;
      tail_idx   = 0;
      used_cnt   = 0;
      free_cnt   = NUM_BUFFERS - RESERVED_SLOTS;
      data_live  = 1'b0;
      user_ctr   = '0;
      irq_ctr    = '0;
      high_mark  = 0;
      mismatches = 0;
      expected_results.delete();
    end else begin
      if (evt.valid && evt.ready)
        expected_results.push_back(ring_event(evt.mode, evt.status_buffer_b_in_use,
                                              evt.status_started_a, evt.status_started_b));
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          if (mismatches < 10) $display("%0t: result transfer with no event outstanding", $time);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("write_accepted",  want.write_accepted,  res.write_accepted);
          check_field("load_a",          want.load_a,          res.load_a);
          check_field("zero_a",          want.zero_a,          res.zero_a);
          check_field("slot_a",          want.slot_a,          res.slot_a);
          check_field("load_b",          want.load_b,          res.load_b);
          check_field("zero_b",          want.zero_b,          res.zero_b);
          check_field("slot_b",          want.slot_b,          res.slot_b);
          check_field("purged_buffers",  want.purged_buffers,  res.purged_buffers);
          check_field("space_available", want.space_available, res.space_available);
          check_field("user_urun_total", want.user_urun_total, res.user_urun_total);
          check_field("irq_urun_total",  want.irq_urun_total,  res.irq_urun_total);
          check_field("high_water",      want.high_water,      res.high_water);
        end
      end
    end
    pending = expected_results.size();
  end

endmodule : ppdbrf_result_check

>>> dv/testbench.sv
// Top of the ring feeder testbench: clock, reset, event stimulus, result stalls and verdict.
`timescale 1ns / 1ps
module testbench;
  import ppdbrf_pkg::*;

  localparam int unsigned       NUM_BUFFERS     = 8;
  localparam logic [MODE_W-1:0] MODE_SPARE      = 2'd3;
  localparam int unsigned       HOLD_OFF_CYCLES = 80;
  localparam int unsigned       PHASE_EVENTS    = 380;

  logic        clk;
  logic        rst;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned evt_gap_pct;
  int unsigned res_gap_pct;
  bit          hold_off_req;

  ppdbrf_evt_if evt_ch ();
  ppdbrf_res_if res_ch ();

  pingpong_dma_buffer_ring_feeder_core #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .evt (evt_ch),
    .res (res_ch)
  );

  ppdbrf_result_check #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) i_result_check (
    .clk        (clk),
    .rst        (rst),
    .evt        (evt_ch),
    .res        (res_ch),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  // Result side: random stalls, and on request one long hold-off so that the block backs up.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
      end
      res_ch.ready <= ($urandom_range(99, 0) >= res_gap_pct);
    end
  end

  // Offers one event from a falling edge and returns at the falling edge after its transfer.
  task automatic send_event(input logic [MODE_W-1:0] mode, input logic b_in_use,
                            input logic started_a, input logic started_b);
    while ($urandom_range(99, 0) < evt_gap_pct) begin
      evt_ch.valid <= 1'b0;
      @(negedge clk);
    end
    evt_ch.valid                  <= 1'b1;
    evt_ch.mode                   <= mode;
    evt_ch.status_buffer_b_in_use <= b_in_use;
    evt_ch.status_started_a       <= started_a;
    evt_ch.status_started_b       <= started_b;
    do @(posedge clk); while (!evt_ch.ready);
    @(negedge clk);
  endtask

  task automatic random_event(input int unsigned write_pct);
    int unsigned       r;
    logic [MODE_W-1:0] mode;
    r = $urandom_range(99, 0);
    if (r < write_pct)  mode = MODE_WRITE;
    else if (r < 93)    mode = MODE_DMA_DONE;
    else if (r < 98)    mode = MODE_PURGE;
    else                mode = MODE_SPARE;
    send_event(mode, $urandom_range(1, 0), $urandom_range(1, 0), $urandom_range(1, 0));
  endtask

  initial begin
    int unsigned sent;
    int unsigned write_pct;
    int unsigned waited;
    rst                           = 1'b1;
    hold_off_req                  = 1'b0;
    evt_gap_pct                   = 31;
    res_gap_pct                   = 45;
    evt_ch.valid                  = 1'b0;
    evt_ch.mode                   = MODE_WRITE;
    evt_ch.status_buffer_b_in_use = 1'b0;
    evt_ch.status_started_a       = 1'b0;
    evt_ch.status_started_b       = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: unused mode, both channels on an empty ring, purges of an empty and a full
    // ring, a rejected write, every status combination, and the end of good data.
    send_event(MODE_SPARE, 1'b0, 1'b0, 1'b0);
    send_event(MODE_DMA_DONE, 1'b0, 1'b0, 1'b0);
    send_event(MODE_PURGE, 1'b0, 1'b0, 1'b0);
    repeat (NUM_BUFFERS - RESERVED_SLOTS + 1) send_event(MODE_WRITE, 1'b0, 1'b0, 1'b0);
    send_event(MODE_PURGE, 1'b1, 1'b1, 1'b1);
    repeat (2) send_event(MODE_WRITE, 1'b1, 1'b0, 1'b1);
    for (int s = 0; s < 8; s++) send_event(MODE_DMA_DONE, s[2], s[1], s[0]);
    send_event(MODE_WRITE, 1'b0, 1'b1, 1'b0);
    send_event(MODE_DMA_DONE, 1'b1, 1'b1, 1'b1);
    send_event(MODE_SPARE, 1'b1, 1'b1, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin evt_gap_pct = 31; res_gap_pct = 45; end
        1:       begin evt_gap_pct = 45; res_gap_pct = 31; end
        default: begin evt_gap_pct = 0;  res_gap_pct = 0;  end
      endcase
      sent = 0;
      if (phase != 1) begin
        // The sender keeps offering throughout the hold-off, so the block must stall its input.
        write_pct   = evt_gap_pct;
        hold_off_req = 1'b1;
        evt_gap_pct = 0;
        repeat (20) random_event(60);
        evt_gap_pct = write_pct;
        sent = 20;
      end
      while (sent < PHASE_EVENTS) begin
        // Bursts lean towards writes or towards refills so the ring reaches both full and empty.
        case ($urandom_range(2, 0))
          0:       write_pct = 20;
          1:       write_pct = 50;
          default: write_pct = 80;
        endcase
        repeat (20) random_event(write_pct);
        sent += 20;
      end
    end
    evt_ch.valid <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule : testbench

>>> filelist.f
rtl/ppdbrf_pkg.sv
rtl/ppdbrf_evt_if.sv
rtl/ppdbrf_res_if.sv
rtl/ppdbrf_event.sv
rtl/pingpong_dma_buffer_ring_feeder_core.sv
rtl/ppdbrf_checker.sv
dv/ppdbrf_result_check.sv
dv/testbench.sv
